>>> sv/dad_pkg.sv
// Package for the date add days unit: widths, calendar constants, control types
// and the month length and leap year helpers. No dependencies.
`default_nettype none
package dad_pkg;

    localparam int YEAR_BITS    = 16;
    localparam int COUNT_BITS   = 16;
    localparam int DAY_BITS     = 5;
    localparam int MONTH_BITS   = 4;
    localparam int RES_BITS     = 9;
    localparam int LEAP_CYCLE   = 400;
    localparam int REDUCE_STEPS = YEAR_BITS - 8;
    localparam int STEP_W       = $clog2(REDUCE_STEPS);
    localparam int CMP_W        = (COUNT_BITS > RES_BITS) ? COUNT_BITS : RES_BITS;

    localparam logic [MONTH_BITS-1:0] MON_JAN = 4'd0;
    localparam logic [MONTH_BITS-1:0] MON_FEB = 4'd1;
    localparam logic [MONTH_BITS-1:0] MON_APR = 4'd3;
    localparam logic [MONTH_BITS-1:0] MON_JUN = 4'd5;
    localparam logic [MONTH_BITS-1:0] MON_SEP = 4'd8;
    localparam logic [MONTH_BITS-1:0] MON_NOV = 4'd10;
    localparam logic [MONTH_BITS-1:0] MON_DEC = 4'd11;

    localparam logic [RES_BITS-1:0] YLEN_LEAP   = 9'd366;
    localparam logic [RES_BITS-1:0] YLEN_COMMON = 9'd365;
    localparam logic [RES_BITS-1:0] RES_100     = 9'd100;
    localparam logic [RES_BITS-1:0] RES_200     = 9'd200;
    localparam logic [RES_BITS-1:0] RES_300     = 9'd300;
    localparam logic [RES_BITS-1:0] RES_LAST    = 9'd399;

    typedef struct packed {
        logic              load;
        logic              reduce;
        logic [STEP_W-1:0] shift;
        logic              check;
        logic              walk;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic walk_done;
    } t_dp_sts;

    // year residue mod 400 -> leap
    function automatic logic leap_of(input logic [RES_BITS-1:0] r);
        logic l;
        l = (r[1:0] == 2'b00) && (r != RES_100) && (r != RES_200) && (r != RES_300);
        return l;
    endfunction

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        case (m) inside
            MON_FEB:                          len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default:                          len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> sv/date_add_days_unit.sv
// Top level of the date add days unit: joins dad_ctrl and dad_datapath.
// Depends on dad_pkg, dad_ctrl, dad_datapath.
//
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------------
// input    | i_in_valid / o_in_stall   | start_day, start_month, start_year, days_to_add
// output   | o_out_valid / i_out_stall | end_day, end_month, end_year, year_overflow,
//          |                           | bad_start
//
// Each item passes through accept, (YEAR_BITS - 8) year reduction steps, the start
// check, one walk step per month (or per whole year from January 1st), the walk exit
// and the push; a bad start skips the walk. The month walk is the longest part.
// Reset is synchronous and clears only the controller.
// One item is in work at a time; a held result waits in the output register
// while the next item is taken and worked on.
`default_nettype none
module date_add_days_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [dad_pkg::DAY_BITS-1:0]    i_start_day,
    input  wire logic [dad_pkg::MONTH_BITS-1:0]  i_start_month,
    input  wire logic [dad_pkg::YEAR_BITS-1:0]   i_start_year,
    input  wire logic [dad_pkg::COUNT_BITS-1:0]  i_days_to_add,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [dad_pkg::DAY_BITS-1:0]         o_end_day,
    output logic [dad_pkg::MONTH_BITS-1:0]       o_end_month,
    output logic [dad_pkg::YEAR_BITS-1:0]        o_end_year,
    output logic                                 o_year_overflow,
    output logic                                 o_bad_start
);

    dad_pkg::t_dp_cmd cmd;
    dad_pkg::t_dp_sts sts;

    dad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dad_datapath u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_start_day     (i_start_day),
        .i_start_month   (i_start_month),
        .i_start_year    (i_start_year),
        .i_days_to_add   (i_days_to_add),
        .o_sts           (sts),
        .o_end_day       (o_end_day),
        .o_end_month     (o_end_month),
        .o_end_year      (o_end_year),
        .o_year_overflow (o_year_overflow),
        .o_bad_start     (o_bad_start)
    );

endmodule
`default_nettype wire

>>> sv/dad_ctrl.sv
// Controller for the date add days unit: sequences load, year reduction, start
// check, month walk and result hand-off. Depends on dad_pkg.
`default_nettype none
module dad_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire dad_pkg::t_dp_sts i_sts,
    output dad_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_CHECK  = 5'b00100,
        S_WALK   = 5'b01000,
        S_PUSH   = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [dad_pkg::STEP_W-1:0]  r_step, n_step;
    logic                        r_out_valid, n_out_valid;
    logic                        in_acc;
    logic                        out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.shift  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    n_step     = dad_pkg::STEP_W'(dad_pkg::REDUCE_STEPS - 1);
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (r_step == '0) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.bad ? S_PUSH : S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result load did not raise valid");

    a_reduce_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE) && (r_step == '0) |=> (r_state == S_CHECK))
        else $error("reduction did not end in check");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && i_sts.walk_done |=> (r_state == S_PUSH))
        else $error("finished walk did not push");

    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) && !out_free |=> (r_state == S_PUSH))
        else $error("push left while output busy");

endmodule
`default_nettype wire

>>> sv/dad_datapath.sv
// Datapath for the date add days unit: date and count registers, year residue
// mod 400, one month, whole-year or last partial-month step per walk command,
// result register. Depends on dad_pkg.
`default_nettype none
module dad_datapath (
    input  wire logic                               i_clk,
    input  wire dad_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [dad_pkg::DAY_BITS-1:0]       i_start_day,
    input  wire logic [dad_pkg::MONTH_BITS-1:0]     i_start_month,
    input  wire logic [dad_pkg::YEAR_BITS-1:0]      i_start_year,
    input  wire logic [dad_pkg::COUNT_BITS-1:0]     i_days_to_add,
    output dad_pkg::t_dp_sts                        o_sts,
    output logic [dad_pkg::DAY_BITS-1:0]            o_end_day,
    output logic [dad_pkg::MONTH_BITS-1:0]          o_end_month,
    output logic [dad_pkg::YEAR_BITS-1:0]           o_end_year,
    output logic                                    o_year_overflow,
    output logic                                    o_bad_start
);

    logic [dad_pkg::DAY_BITS-1:0]   r_day;
    logic [dad_pkg::MONTH_BITS-1:0] r_month;
    logic [dad_pkg::YEAR_BITS-1:0]  r_year;
    logic [dad_pkg::YEAR_BITS-1:0]  r_rem;
    logic [dad_pkg::COUNT_BITS-1:0] r_count;
    logic                           r_ovf;
    logic                           r_bad;

    logic [dad_pkg::DAY_BITS-1:0]   r_out_day;
    logic [dad_pkg::MONTH_BITS-1:0] r_out_month;
    logic [dad_pkg::YEAR_BITS-1:0]  r_out_year;
    logic                           r_out_ovf;
    logic                           r_out_bad;

    logic [dad_pkg::YEAR_BITS-1:0]  bound;
    logic [dad_pkg::RES_BITS-1:0]   res;
    logic                           leap;
    logic [dad_pkg::DAY_BITS-1:0]   len;
    logic [dad_pkg::DAY_BITS-1:0]   rest;
    logic [dad_pkg::RES_BITS-1:0]   ylen;
    logic [dad_pkg::CMP_W-1:0]      cnt_x;
    logic                           skip;
    logic                           past_month;
    logic                           year_max;
    logic [dad_pkg::RES_BITS-1:0]   res_inc;

    assign bound      = dad_pkg::YEAR_BITS'(dad_pkg::LEAP_CYCLE) << i_cmd.shift;
    assign res        = r_rem[dad_pkg::RES_BITS-1:0];
    assign leap       = dad_pkg::leap_of(res);
    assign len        = dad_pkg::month_len(r_month, leap);
    assign rest       = len - r_day;
    assign ylen       = leap ? dad_pkg::YLEN_LEAP : dad_pkg::YLEN_COMMON;
    assign cnt_x      = dad_pkg::CMP_W'(r_count);
    assign skip       = (r_month == dad_pkg::MON_JAN) && (r_day == '0)
                        && (cnt_x > dad_pkg::CMP_W'(ylen));
    assign past_month = cnt_x > dad_pkg::CMP_W'(rest);
    assign year_max   = (r_year == '1);
    assign res_inc    = (res == dad_pkg::RES_LAST) ? '0 : res + 1'b1;

    assign o_sts.bad       = (r_month > dad_pkg::MON_DEC) || (r_day == '0) || (r_day > len);
    assign o_sts.walk_done = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= i_start_day;
            r_month <= i_start_month;
            r_year  <= i_start_year;
            r_rem   <= i_start_year;
            r_count <= i_days_to_add;
            r_ovf   <= 1'b0;
        end
        if (i_cmd.reduce && (r_rem >= bound)) begin
            r_rem <= r_rem - bound;
        end
        if (i_cmd.check) begin
            r_bad <= o_sts.bad;
        end
        if (i_cmd.walk) begin
            if (skip || (past_month && (r_month == dad_pkg::MON_DEC))) begin
                if (year_max) begin
                    r_year <= '0;
                    r_rem  <= '0;
                    r_ovf  <= 1'b1;
                end else begin
                    r_year <= r_year + 1'b1;
                    r_rem  <= dad_pkg::YEAR_BITS'(res_inc);
                end
            end
            if (skip) begin
                r_count <= dad_pkg::COUNT_BITS'(cnt_x - dad_pkg::CMP_W'(ylen));
            end else if (past_month) begin
                r_count <= r_count - dad_pkg::COUNT_BITS'(rest);
                r_day   <= '0;
                r_month <= (r_month == dad_pkg::MON_DEC) ? dad_pkg::MON_JAN
                                                         : r_month + 1'b1;
            end else begin
                r_day   <= r_day + r_count[dad_pkg::DAY_BITS-1:0];
                r_count <= '0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_day   <= r_day;
            r_out_month <= r_month;
            r_out_year  <= r_year;
            r_out_ovf   <= r_ovf && !r_bad;
            r_out_bad   <= r_bad;
        end
    end

    assign o_end_day       = r_out_day;
    assign o_end_month     = r_out_month;
    assign o_end_year      = r_out_year;
    assign o_year_overflow = r_out_ovf;
    assign o_bad_start     = r_out_bad;

endmodule
`default_nettype wire
